/* rtl/mch_pkg.sv */
// Shared types, widths and constants of the magnetometer calibration and heading unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package mch_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int SW       = SAMPLE_WIDTH;
	localparam int CFG_W    = 12;
	localparam int CW       = SW + 2;            // corrected value
	localparam int OFF_W    = SW + 1;            // min + max
	localparam int SPAN_W   = SW + 1;
	localparam int SUM_W    = SPAN_W + 2;
	localparam int NUM_W    = SUM_W + 18;        // 2 * sum * 2^16 + 3 * span
	localparam int DEN_W    = SPAN_W + 3;        // 6 * span
	localparam int SCALE_W  = 24;
	localparam int PROD_W   = CW + SCALE_W + 1;
	localparam int RND_W    = PROD_W - 17;
	localparam int X_W      = CW + 24 + 3;
	localparam int Z_W      = 26;
	localparam int HEAD_W   = 16;
	localparam int DIV_STEPS = NUM_W;
	localparam int ITER_W   = $clog2(CORDIC_STEPS);
	localparam int STEP_W   = $clog2((DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS);

	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(200);
	localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
	localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(4608000);
	localparam logic signed [Z_W-1:0] FULL_TURN = Z_W'(9216000);
	localparam logic [HEAD_W-1:0]  HEAD_ZERO = HEAD_W'(18000);

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAL,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_DIV_STORE,
		ST_MUL,
		ST_SAT,
		ST_COR_INIT,
		ST_COR_STEP,
		ST_COR_STORE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              load_in;
		logic              cal_update;
		logic              div_init;
		logic              div_step;
		logic              div_store;
		logic              set_cal;
		logic              mul;
		logic              sat_store;
		logic              cor_init;
		logic              cor_step;
		logic              cor_store;
		logic              out_load;
		logic [1:0]        ax;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic calibrated;
		logic cal_finish;
	} status_t;

	// atan(2^-i) in 1/256 of a hundredth of a degree
	function automatic logic signed [Z_W-1:0] atan_unit(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		begin
			unique case (i)
				5'd0: r = Z_W'(1152000);
				5'd1: r = Z_W'(680065);
				5'd2: r = Z_W'(359328);
				5'd3: r = Z_W'(182400);
				5'd4: r = Z_W'(91554);
				5'd5: r = Z_W'(45822);
				5'd6: r = Z_W'(22916);
				5'd7: r = Z_W'(11459);
				5'd8: r = Z_W'(5730);
				5'd9: r = Z_W'(2865);
				5'd10: r = Z_W'(1432);
				5'd11: r = Z_W'(716);
				5'd12: r = Z_W'(358);
				5'd13: r = Z_W'(179);
				5'd14: r = Z_W'(90);
				5'd15: r = Z_W'(45);
				5'd16: r = Z_W'(22);
				5'd17: r = Z_W'(11);
				5'd18: r = Z_W'(6);
				5'd19: r = Z_W'(3);
				5'd20: r = Z_W'(1);
				5'd21: r = Z_W'(1);
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/mch_if.sv */
// Valid/ready channel interfaces for sample items and result items.
// Depends on mch_pkg for field widths.
`default_nettype none

interface mch_in_if;
	import mch_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [SW-1:0] sample_x;
	logic signed [SW-1:0] sample_y;
	logic signed [SW-1:0] sample_z;
	modport source(output valid, sample_x, sample_y, sample_z, input ready);
	modport sink(input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface mch_out_if;
	import mch_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] corrected_x;
	logic signed [CW-1:0] corrected_y;
	logic signed [CW-1:0] corrected_z;
	logic [HEAD_W-1:0]    heading_xy;
	logic [HEAD_W-1:0]    heading_xz;
	logic [HEAD_W-1:0]    heading_yz;
	logic                 saturated;
	modport source(output valid, corrected_x, corrected_y, corrected_z,
		heading_xy, heading_xz, heading_yz, saturated, input ready);
	modport sink(input valid, corrected_x, corrected_y, corrected_z,
		heading_xy, heading_xz, heading_yz, saturated, output ready);
endinterface

`default_nettype wire

/* rtl/mch_ctrl.sv */
// Sequencer: steps the datapath through calibration, scale division, correction and CORDIC.
// Depends on mch_pkg (state_t, cmd_t, status_t).
`default_nettype none

module mch_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire mch_pkg::status_t status,
	output mch_pkg::cmd_t        cmd
);
	import mch_pkg::*;

	state_t            state_q, state_nx;
	logic [1:0]        ax_q, ax_nx;
	logic [STEP_W-1:0] step_q, step_nx;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= AXIS_X;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			ax_q    <= ax_nx;
			step_q  <= step_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx = state_q;
		ax_nx    = ax_q;
		step_nx  = step_q;
		cmd      = '0;
		cmd.ax   = ax_q;
		cmd.step = step_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					ax_nx       = AXIS_X;
					state_nx    = status.calibrated ? ST_MUL : ST_CAL;
				end
			end
			ST_CAL: begin
				cmd.cal_update = 1'b1;
				ax_nx          = AXIS_X;
				state_nx       = status.cal_finish ? ST_DIV_INIT : ST_IDLE;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				step_nx      = '0;
				state_nx     = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				cmd.div_step = 1'b1;
				step_nx      = step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1))
					state_nx = ST_DIV_STORE;
			end
			ST_DIV_STORE: begin
				cmd.div_store = 1'b1;
				if (ax_q == AXIS_LAST) begin
					cmd.set_cal = 1'b1;
					state_nx    = ST_IDLE;
				end else begin
					ax_nx    = ax_q + 1'b1;
					state_nx = ST_DIV_INIT;
				end
			end
			ST_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat_store = 1'b1;
				if (ax_q == AXIS_LAST) begin
					ax_nx    = AXIS_X;
					state_nx = ST_COR_INIT;
				end else begin
					ax_nx    = ax_q + 1'b1;
					state_nx = ST_MUL;
				end
			end
			ST_COR_INIT: begin
				cmd.cor_init = 1'b1;
				step_nx      = '0;
				state_nx     = ST_COR_STEP;
			end
			ST_COR_STEP: begin
				cmd.cor_step = 1'b1;
				step_nx      = step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1))
					state_nx = ST_COR_STORE;
			end
			ST_COR_STORE: begin
				cmd.cor_store = 1'b1;
				if (ax_q == AXIS_LAST) begin
					state_nx = ST_DONE;
				end else begin
					ax_nx    = ax_q + 1'b1;
					state_nx = ST_COR_INIT;
				end
			end
			ST_DONE: begin
				// result register is free once the previous item has been taken
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_cal_only_uncal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cal_update |-> !status.calibrated) else $error("calibration update after calibration");
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(status.calibrated)) else $error("calibrated flag dropped");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready)) else $error("result overwritten");
	a_ax_range: assert property (@(posedge clk) disable iff (!arst_n)
		ax_q != 2'd3) else $error("axis index out of range");
`endif

endmodule

`default_nettype wire

/* rtl/mch_dp.sv */
// Datapath: min/max tracking, shared restoring divider for scales, shared multiplier
// for correction, shared CORDIC for headings, result register. Depends on mch_pkg.
`default_nettype none

module mch_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mch_pkg::cmd_t             cmd,
	output mch_pkg::status_t               status,
	input  wire logic                      cfg_wr_en,
	input  wire logic [mch_pkg::CFG_W-1:0] cfg_wr_data,
	input  wire logic signed [mch_pkg::SW-1:0] in_x,
	input  wire logic signed [mch_pkg::SW-1:0] in_y,
	input  wire logic signed [mch_pkg::SW-1:0] in_z,
	output logic signed [mch_pkg::CW-1:0]  res_x,
	output logic signed [mch_pkg::CW-1:0]  res_y,
	output logic signed [mch_pkg::CW-1:0]  res_z,
	output logic [mch_pkg::HEAD_W-1:0]     res_hxy,
	output logic [mch_pkg::HEAD_W-1:0]     res_hxz,
	output logic [mch_pkg::HEAD_W-1:0]     res_hyz,
	output logic                           res_sat
);
	import mch_pkg::*;

	logic [CFG_W-1:0]        cfg_q, cnt_q, cnt_nx, need;
	logic                    cal_q, clip_q;
	logic signed [SW-1:0]    smp_q [3];
	logic signed [SW-1:0]    min_q [3];
	logic signed [SW-1:0]    max_q [3];
	logic signed [OFF_W-1:0] off_q [3];
	logic [SCALE_W-1:0]      scale_q [3];
	logic signed [CW-1:0]    c_q [3];
	logic [2:0]              csat_q;
	logic [HEAD_W-1:0]       head_q [3];

	logic [SPAN_W-1:0]       span [3];
	logic [SUM_W-1:0]        sum;
	logic [NUM_W-1:0]        num_q;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W-1:0]        rem_q;
	logic [NUM_W-1:0]        quo_q;
	logic [DEN_W:0]          trial;

	logic signed [CW-1:0]     d2;
	logic signed [PROD_W-1:0] prod_q, prod_w;
	logic signed [PROD_W-1:0] rnd;
	logic signed [RND_W-1:0]  v;

	logic signed [CW-1:0]    op_a, op_b;
	logic signed [X_W-1:0]   xb, ya, x_q, y_q, xs, ys;
	logic signed [Z_W-1:0]   z_q, h;
	logic                    zero_q;
	logic [ITER_W-1:0]       iter;
	logic [HEAD_W-1:0]       hd;

	// calibration end test
	assign cnt_nx = cnt_q + 1'b1;
	assign need   = (cfg_q == '0) ? CFG_W'(1) : cfg_q;
	assign status.cal_finish = (cnt_nx == '0) || (cnt_nx >= need);
	assign status.calibrated = cal_q;

	always_comb begin
		for (int k = 0; k < 3; k++)
			span[k] = SPAN_W'({max_q[k][SW-1], max_q[k]} - {min_q[k][SW-1], min_q[k]});
	end
	assign sum   = SUM_W'(span[0]) + SUM_W'(span[1]) + SUM_W'(span[2]);
	assign trial = {rem_q, num_q[NUM_W-1]};

	// correction multiply
	assign d2     = CW'($signed({smp_q[cmd.ax], 1'b0})) - CW'(off_q[cmd.ax]);
	assign prod_w = PROD_W'(d2) * $signed({1'b0, scale_q[cmd.ax]});
	assign rnd    = prod_q + PROD_W'(65536);
	assign v      = RND_W'(rnd >>> 17);

	// CORDIC operand selection by pair
	always_comb begin
		unique case (cmd.ax)
			2'd0: begin op_a = c_q[0]; op_b = c_q[1]; end
			2'd1: begin op_a = c_q[0]; op_b = c_q[2]; end
			default: begin op_a = c_q[1]; op_b = c_q[2]; end
		endcase
	end
	assign xb   = X_W'(op_b) <<< 24;
	assign ya   = X_W'(op_a) <<< 24;
	assign iter = cmd.step[ITER_W-1:0];
	assign xs   = x_q >>> iter;
	assign ys   = y_q >>> iter;
	assign h    = HALF_TURN - z_q;

	always_comb begin
		if (h < 0)
			hd = '0;
		else if (h > FULL_TURN)
			hd = HEAD_W'((FULL_TURN + Z_W'(128)) >>> 8);
		else
			hd = HEAD_W'((h + Z_W'(128)) >>> 8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= CFG_RESET;
			cnt_q  <= '0;
			cal_q  <= 1'b0;
			clip_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				min_q[k]   <= '0;
				max_q[k]   <= '0;
				off_q[k]   <= '0;
				scale_q[k] <= SCALE_ONE;
			end
		end else begin
			if (cfg_wr_en)
				cfg_q <= cfg_wr_data;
			if (cmd.cal_update) begin
				cnt_q <= cnt_nx;
				for (int k = 0; k < 3; k++) begin
					if (cnt_q == '0 || smp_q[k] < min_q[k])
						min_q[k] <= smp_q[k];
					if (cnt_q == '0 || smp_q[k] > max_q[k])
						max_q[k] <= smp_q[k];
				end
			end
			if (cmd.div_store) begin
				off_q[cmd.ax] <= OFF_W'(min_q[cmd.ax]) + OFF_W'(max_q[cmd.ax]);
				if (span[cmd.ax] == '0 || quo_q > NUM_W'(SCALE_MAX)) begin
					scale_q[cmd.ax] <= SCALE_MAX;
					clip_q          <= 1'b1;
				end else begin
					scale_q[cmd.ax] <= quo_q[SCALE_W-1:0];
				end
			end
			if (cmd.set_cal)
				cal_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			smp_q[0] <= in_x;
			smp_q[1] <= in_y;
			smp_q[2] <= in_z;
		end
		// scale = floor((2*sum*2^16 + 3*span) / (6*span)), one quotient bit a cycle
		if (cmd.div_init) begin
			num_q <= NUM_W'({sum, 17'b0}) + NUM_W'(span[cmd.ax])
				+ NUM_W'({span[cmd.ax], 1'b0});
			den_q <= DEN_W'({span[cmd.ax], 2'b0}) + DEN_W'({span[cmd.ax], 1'b0});
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
		if (cmd.mul)
			prod_q <= prod_w;
		if (cmd.sat_store) begin
			if (v > RND_W'((1 << (CW - 1)) - 1)) begin
				c_q[cmd.ax]    <= {1'b0, {(CW-1){1'b1}}};
				csat_q[cmd.ax] <= 1'b1;
			end else if (v < -RND_W'(1 << (CW - 1))) begin
				c_q[cmd.ax]    <= {1'b1, {(CW-1){1'b0}}};
				csat_q[cmd.ax] <= 1'b1;
			end else begin
				c_q[cmd.ax]    <= v[CW-1:0];
				csat_q[cmd.ax] <= 1'b0;
			end
		end
		if (cmd.cor_init) begin
			zero_q <= (op_a == '0) && (op_b == '0);
			if (op_b < 0) begin
				x_q <= -xb;
				y_q <= -ya;
				z_q <= (op_a >= 0) ? HALF_TURN : -HALF_TURN;
			end else begin
				x_q <= xb;
				y_q <= ya;
				z_q <= '0;
			end
		end
		if (cmd.cor_step) begin
			if (!y_q[X_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_unit(5'(iter));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_unit(5'(iter));
			end
		end
		if (cmd.cor_store)
			head_q[cmd.ax] <= zero_q ? HEAD_ZERO : hd;
		if (cmd.out_load) begin
			res_x   <= c_q[0];
			res_y   <= c_q[1];
			res_z   <= c_q[2];
			res_hxy <= head_q[0];
			res_hxz <= head_q[1];
			res_hyz <= head_q[2];
			res_sat <= clip_q | (|csat_q);
		end
	end

`ifndef SYNTHESIS
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (rem_q < den_q)) else $error("divider remainder out of range");
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cor_store |-> (hd <= HEAD_W'(36000))) else $error("heading out of range");
	a_cnt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		cal_q |=> $stable(cnt_q)) else $error("count moved after calibration");
`endif

endmodule

`default_nettype wire

/* rtl/magnetometer_calibrate_and_heading_unit.sv */
// Magnetometer calibration and heading unit. The first calibration_samples items
// (reset 200, zero acts as one) only update per-axis min/max and give no result;
// the last of them also divides out the three Q8.16 scales, one axis after another,
// on a one-bit-per-cycle restoring divider. Every later item gives one result: the
// shared multiplier corrects the three axes, one shared 16-step CORDIC gives the
// three headings, and the result register is loaded once it is free; a new item is
// taken only after the previous one has been loaded into the result register.
// One item is in work at a time; the next is taken while the previous result waits.
// Depends on mch_pkg, mch_if, mch_ctrl and mch_dp.
`default_nettype none

module magnetometer_calibrate_and_heading_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [mch_pkg::CFG_W-1:0] cfg_wr_data,
	mch_in_if.sink                         sample_in,
	mch_out_if.source                      result_out
);
	import mch_pkg::*;

	cmd_t    cmd;
	status_t status;

	mch_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_in.valid),
		.in_ready  (sample_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mch_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_x        (sample_in.sample_x),
		.in_y        (sample_in.sample_y),
		.in_z        (sample_in.sample_z),
		.res_x       (result_out.corrected_x),
		.res_y       (result_out.corrected_y),
		.res_z       (result_out.corrected_z),
		.res_hxy     (result_out.heading_xy),
		.res_hxz     (result_out.heading_xz),
		.res_hyz     (result_out.heading_yz),
		.res_sat     (result_out.saturated)
	);

endmodule

`default_nettype wire
